@@ src/fsp_pkg.sv @@
package fsp_pkg;

    // Character codes recognized inside a conversion specifier
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_H     = 8'h68;

    // Bit positions in the flag mask
    localparam int FL_HASH  = 0;
    localparam int FL_ZERO  = 1;
    localparam int FL_DASH  = 2;
    localparam int FL_SPACE = 3;
    localparam int FL_PLUS  = 4;

    // Bit positions in the length mask
    localparam int LEN_L  = 0;
    localparam int LEN_LL = 1;
    localparam int LEN_H  = 2;
    localparam int LEN_HH = 3;

    // Largest value a width or precision run may reach
    localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_WIDTH_RUN  = 3'd1,
        MODE_PREC_FIRST = 3'd2,
        MODE_PREC_RUN   = 3'd3,
        MODE_PEND_L     = 3'd4,
        MODE_PEND_H     = 3'd5
    } t_mode;

    typedef struct packed {
        logic [4:0]         flags;
        logic [30:0]        width;
        logic signed [31:0] prec;
        logic               prec_open;
        logic               prec_closed;
        logic [3:0]         len;
        t_mode              mode;
    } t_parse_state;

    typedef struct packed {
        logic [7:0]         conversion_char;
        logic [4:0]         flag_mask;
        logic [30:0]        min_width;
        logic signed [31:0] precision_amount;
        logic               precision_open;
        logic               precision_closed;
        logic [3:0]         length_mask;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{
        flags:       5'd0,
        width:       31'd0,
        prec:        32'sd1,
        prec_open:   1'b0,
        prec_closed: 1'b0,
        len:         4'd0,
        mode:        MODE_NORMAL
    };

endpackage

@@ src/fsp_in_if.sv @@
interface fsp_in_if;
    import fsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         spec_char;
    logic signed [31:0] star_arg;
    logic               spec_start;

    modport source (output valid, output spec_char, output star_arg, output spec_start,
                    input ready);
    modport sink   (input valid, input spec_char, input star_arg, input spec_start,
                    output ready);
endinterface

@@ src/fsp_out_if.sv @@
interface fsp_out_if;
    import fsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         conversion_char;
    logic [4:0]         flag_mask;
    logic [30:0]        min_width;
    logic signed [31:0] precision_amount;
    logic               precision_open;
    logic               precision_closed;
    logic [3:0]         length_mask;

    modport source (output valid, output conversion_char, output flag_mask,
                    output min_width, output precision_amount, output precision_open,
                    output precision_closed, output length_mask, input ready);
    modport sink   (input valid, input conversion_char, input flag_mask,
                    input min_width, input precision_amount, input precision_open,
                    input precision_closed, input length_mask, output ready);
endinterface

@@ src/fsp_step.sv @@
module fsp_step
    import fsp_pkg::*;
(
    input  t_parse_state       i_state,
    input  logic [7:0]         i_char,
    input  logic signed [31:0] i_arg,
    input  logic               i_start,
    output t_parse_state       o_state,
    output logic               o_emit,
    output t_result            o_result
);

    // Append one decimal digit, clamp at the largest run value
    function automatic logic [31:0] sat_append(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] sum;
        begin
            sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, d};
            if (sum > {5'd0, SAT_MAX}) begin
                sat_append = {1'b0, SAT_MAX};
            end else begin
                sat_append = sum[31:0];
            end
        end
    endfunction

    t_parse_state s;
    t_parse_state nx;
    logic         fall;
    logic         is_digit;
    logic [3:0]   digit;
    logic         neg;
    logic [31:0]  mag;
    logic [31:0]  wsum;
    logic [4:0]   fl;

    always_comb begin
        s        = i_start ? PARSE_RESET : i_state;
        nx       = s;
        fall     = 1'b0;
        o_emit   = 1'b0;
        o_result = '0;
        is_digit = (i_char inside {[CH_ZERO:CH_NINE]});
        digit    = 4'(i_char - CH_ZERO);
        neg      = i_arg[31];
        mag      = ~i_arg + 32'd1;
        wsum     = 32'd0;
        fl       = 5'd0;

        // Finish whatever the previous character left open
        case (s.mode)
            MODE_PEND_L: begin
                nx.mode = MODE_NORMAL;
                if (i_char == CH_L) begin
                    nx.len[LEN_LL] = 1'b1;
                end else begin
                    nx.len[LEN_L] = 1'b1;
                    fall = 1'b1;
                end
            end
            MODE_PEND_H: begin
                nx.mode = MODE_NORMAL;
                if (i_char == CH_H) begin
                    nx.len[LEN_HH] = 1'b1;
                end else begin
                    nx.len[LEN_H] = 1'b1;
                    fall = 1'b1;
                end
            end
            MODE_PREC_FIRST: begin
                nx.mode = MODE_NORMAL;
                if (i_char == CH_STAR) begin
                    nx.prec = i_arg;
                    if (neg) begin
                        nx.prec_open = 1'b0;
                    end else begin
                        nx.prec_closed = 1'b1;
                    end
                end else begin
                    nx.prec_closed = 1'b1;
                    if (is_digit) begin
                        nx.prec = {28'd0, digit};
                        nx.mode = MODE_PREC_RUN;
                    end else begin
                        nx.prec = 32'sd0;
                        fall = 1'b1;
                    end
                end
            end
            MODE_PREC_RUN: begin
                if (is_digit) begin
                    nx.prec = sat_append(s.prec, digit);
                end else begin
                    nx.mode = MODE_NORMAL;
                    fall = 1'b1;
                end
            end
            MODE_WIDTH_RUN: begin
                if (is_digit) begin
                    wsum = sat_append({1'b0, s.width}, digit);
                    nx.width = wsum[30:0];
                end else begin
                    nx.mode = MODE_NORMAL;
                    fall = 1'b1;
                end
            end
            default: begin
                nx.mode = MODE_NORMAL;
                fall = 1'b1;
            end
        endcase

        // Handle the character as the start of a new element
        if (fall) begin
            if (i_char == CH_HASH || i_char == CH_ZERO || i_char == CH_DASH ||
                i_char == CH_SPACE || i_char == CH_PLUS) begin
                fl = nx.flags;
                case (i_char)
                    CH_HASH:  fl[FL_HASH]  = 1'b1;
                    CH_ZERO:  fl[FL_ZERO]  = 1'b1;
                    CH_DASH:  fl[FL_DASH]  = 1'b1;
                    CH_SPACE: fl[FL_SPACE] = 1'b1;
                    default:  fl[FL_PLUS]  = 1'b1;
                endcase
                if (fl[FL_DASH] || nx.prec_open) begin
                    fl[FL_ZERO] = 1'b0;
                end
                if (fl[FL_PLUS]) begin
                    fl[FL_SPACE] = 1'b0;
                end
                nx.flags = fl;
            end else if (i_char == CH_DOT) begin
                nx.prec_open   = 1'b1;
                nx.prec_closed = 1'b0;
                nx.mode        = MODE_PREC_FIRST;
            end else if (is_digit) begin
                nx.width = {27'd0, digit};
                nx.mode  = MODE_WIDTH_RUN;
            end else if (i_char == CH_STAR) begin
                if (neg) begin
                    nx.width = mag[31] ? SAT_MAX : mag[30:0];
                    nx.flags[FL_DASH] = 1'b1;
                end else begin
                    nx.width = i_arg[30:0];
                end
            end else if (i_char == CH_L) begin
                nx.mode = MODE_PEND_L;
            end else if (i_char == CH_H) begin
                nx.mode = MODE_PEND_H;
            end else begin
                // Terminating character: report and clear
                o_emit                    = 1'b1;
                o_result.conversion_char  = i_char;
                o_result.flag_mask        = nx.flags;
                o_result.min_width        = nx.width;
                o_result.precision_amount = nx.prec;
                o_result.precision_open   = nx.prec_open;
                o_result.precision_closed = nx.prec_closed;
                o_result.length_mask      = nx.len;
                nx                        = PARSE_RESET;
            end
        end

        o_state = nx;
    end

endmodule

@@ src/format_specifier_flag_parser.sv @@
// Channel  Dir  Fields                                             Handshake
// i_in     in   spec_char, star_arg, spec_start                    valid/ready
// o_out    out  conversion_char, flag_mask, min_width,             valid/ready
//               precision_amount, precision_open, precision_closed,
//               length_mask
//
// One character per cycle unless a stalled result blocks a terminating character.
// A request lands in the input register, is parsed against the registered parse state and,
// if it ends the specifier, fills the result register.
// Synchronous active-low reset clears the valid bits and the parse state.
// A stalled result holds only terminating characters; others keep flowing past it.
module format_specifier_flag_parser
    import fsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsp_in_if.sink    i_in,
    fsp_out_if.source o_out
);

    logic               r_in_valid;
    logic [7:0]         r_char;
    logic signed [31:0] r_arg;
    logic               r_start;
    t_parse_state       r_state;
    t_parse_state       n_state;
    logic               r_out_valid;
    t_result            r_result;
    t_result            n_result;
    logic               emit;
    logic               out_free;
    logic               consume;

    fsp_step u_step (
        .i_state  (r_state),
        .i_char   (r_char),
        .i_arg    (r_arg),
        .i_start  (r_start),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_result (n_result)
    );

    // Retire the held request unless its result has nowhere to go
    assign out_free    = !r_out_valid || o_out.ready;
    assign consume     = r_in_valid && (!emit || out_free);
    assign i_in.ready  = !r_in_valid || consume;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= PARSE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (consume) begin
                r_state <= n_state;
            end
            if (consume && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_char  <= i_in.spec_char;
            r_arg   <= i_in.star_arg;
            r_start <= i_in.spec_start;
        end
        if (consume && emit) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.conversion_char  = r_result.conversion_char;
    assign o_out.flag_mask        = r_result.flag_mask;
    assign o_out.min_width        = r_result.min_width;
    assign o_out.precision_amount = r_result.precision_amount;
    assign o_out.precision_open   = r_result.precision_open;
    assign o_out.precision_closed = r_result.precision_closed;
    assign o_out.length_mask      = r_result.length_mask;

endmodule

@@ bench/tb_format_specifier_flag_parser.sv @@
`timescale 1ns / 100ps

module tb_format_specifier_flag_parser;
    import fsp_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_CHARS = 740;

    // Shadow parser: mirrors the parse state and queues the results it predicts
    class spec_predictor;
        t_parse_state st;
        t_result      pending_results[$];
        int           n_chars;
        int           n_results;
        int           n_errors;

        function new();
            st        = PARSE_RESET;
            n_chars   = 0;
            n_results = 0;
            n_errors  = 0;
        endfunction

        // Append one decimal digit, saturating at the largest run value
        function logic [31:0] append_digit(logic [31:0] acc, logic [7:0] c);
            logic [31:0] d;
            d = {24'd0, c - CH_ZERO};
            if (acc > ({1'b0, SAT_MAX} - d) / 10) return {1'b0, SAT_MAX};
            return acc * 10 + d;
        endfunction

        // Advance the shadow state by one accepted request
        function void note_char(logic [7:0] c, logic [31:0] arg, logic start);
            logic        is_dig;
            logic [31:0] mag;
            t_result     r;
            n_chars++;
            is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
            if (start) st = PARSE_RESET;

            // Resolve the pending sub-state first
            case (st.mode)
                MODE_PEND_L: begin
                    st.mode = MODE_NORMAL;
                    if (c == CH_L) begin
                        st.len[LEN_LL] = 1'b1;
                        return;
                    end
                    st.len[LEN_L] = 1'b1;
                end
                MODE_PEND_H: begin
                    st.mode = MODE_NORMAL;
                    if (c == CH_H) begin
                        st.len[LEN_HH] = 1'b1;
                        return;
                    end
                    st.len[LEN_H] = 1'b1;
                end
                MODE_PREC_FIRST: begin
                    st.mode = MODE_NORMAL;
                    if (c == CH_STAR) begin
                        st.prec = arg;
                        if (arg[31]) st.prec_open = 1'b0;
                        else st.prec_closed = 1'b1;
                        return;
                    end
                    st.prec_closed = 1'b1;
                    if (is_dig) begin
                        st.prec = {24'd0, c - CH_ZERO};
                        st.mode = MODE_PREC_RUN;
                        return;
                    end
                    // empty precision counts as zero
                    st.prec = 32'sd0;
                end
                MODE_PREC_RUN: begin
                    if (is_dig) begin
                        st.prec = append_digit(st.prec, c);
                        return;
                    end
                    st.mode = MODE_NORMAL;
                end
                MODE_WIDTH_RUN: begin
                    if (is_dig) begin
                        mag      = append_digit({1'b0, st.width}, c);
                        st.width = mag[30:0];
                        return;
                    end
                    st.mode = MODE_NORMAL;
                end
                default: begin
                    st.mode = MODE_NORMAL;
                end
            endcase

            // Handle the character in normal mode
            case (c)
                CH_HASH, CH_ZERO, CH_DASH, CH_SPACE, CH_PLUS: begin
                    case (c)
                        CH_HASH:  st.flags[FL_HASH]  = 1'b1;
                        CH_ZERO:  st.flags[FL_ZERO]  = 1'b1;
                        CH_DASH:  st.flags[FL_DASH]  = 1'b1;
                        CH_SPACE: st.flags[FL_SPACE] = 1'b1;
                        default:  st.flags[FL_PLUS]  = 1'b1;
                    endcase
                    if (st.flags[FL_DASH] || st.prec_open) st.flags[FL_ZERO] = 1'b0;
                    if (st.flags[FL_PLUS]) st.flags[FL_SPACE] = 1'b0;
                end
                CH_DOT: begin
                    st.prec_open   = 1'b1;
                    st.prec_closed = 1'b0;
                    st.mode        = MODE_PREC_FIRST;
                end
                CH_STAR: begin
                    // negative width flips sign and sets dash without touching zero
                    if (arg[31]) begin
                        mag      = ~arg + 32'd1;
                        st.width = (mag > {1'b0, SAT_MAX}) ? SAT_MAX : mag[30:0];
                        st.flags[FL_DASH] = 1'b1;
                    end else begin
                        st.width = arg[30:0];
                    end
                end
                CH_L: st.mode = MODE_PEND_L;
                CH_H: st.mode = MODE_PEND_H;
                default: begin
                    if (is_dig) begin
                        st.width = {23'd0, c - CH_ZERO};
                        st.mode  = MODE_WIDTH_RUN;
                    end else begin
                        r.conversion_char  = c;
                        r.flag_mask        = st.flags;
                        r.min_width        = st.width;
                        r.precision_amount = st.prec;
                        r.precision_open   = st.prec_open;
                        r.precision_closed = st.prec_closed;
                        r.length_mask      = st.len;
                        pending_results.push_back(r);
                        st = PARSE_RESET;
                    end
                end
            endcase
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result against the oldest prediction
        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got conversion char %0h",
                         $time, got.conversion_char);
                return;
            end
            want = pending_results.pop_front();
            cmp_field("conversion_char", want.conversion_char, got.conversion_char);
            cmp_field("flag_mask", want.flag_mask, got.flag_mask);
            cmp_field("min_width", want.min_width, got.min_width);
            cmp_field("precision_amount", want.precision_amount, got.precision_amount);
            cmp_field("precision_open", want.precision_open, got.precision_open);
            cmp_field("precision_closed", want.precision_closed, got.precision_closed);
            cmp_field("length_mask", want.length_mask, got.length_mask);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsp_in_if  in_if();
    fsp_out_if out_if();

    format_specifier_flag_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    spec_predictor sb = new();
    t_result       got_res;
    logic [7:0]    spec_chars[$];
    int            sent_chars = 0;
    int            cycle_count = 0;
    logic          send_idle = 1'b1;
    logic          recv_idle = 1'b1;
    logic          hold_req = 1'b0;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     sb.pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_res.conversion_char  = out_if.conversion_char;
            got_res.flag_mask        = out_if.flag_mask;
            got_res.min_width        = out_if.min_width;
            got_res.precision_amount = out_if.precision_amount;
            got_res.precision_open   = out_if.precision_open;
            got_res.precision_closed = out_if.precision_closed;
            got_res.length_mask      = out_if.length_mask;
            sb.check_result(got_res);
        end
    end

    // Receiver: random stalls per result, plus one long hold on request
    initial begin
        int gap;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            recv_idle = ((sb.n_results / 25) % 3) != 2;
            if (hold_req) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = recv_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_char(input logic [7:0] c, input logic [31:0] arg, input logic start);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.spec_char  = c;
        in_if.star_arg   = arg;
        in_if.spec_start = start;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_char(c, arg, start);
        sent_chars++;
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic send_text(input string s, input logic start);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 32'd0, start && (i == 0));
    endtask

    // Star argument: mostly extremes and small values
    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    // Queue a digit run; a few are long enough to saturate
    task automatic add_digits(input int first_low);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 3);
        spec_chars.push_back(8'(CH_ZERO + $urandom_range(first_low, 9)));
        repeat (n) spec_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Build and send one well-formed specifier with random content
    task automatic send_random_spec();
        int         n;
        logic [7:0] c;
        logic       mark;
        spec_chars.delete();
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: c = CH_HASH;
                1: c = CH_ZERO;
                2: c = CH_DASH;
                3: c = CH_SPACE;
                default: c = CH_PLUS;
            endcase
            spec_chars.push_back(c);
        end
        // width
        case ($urandom_range(0, 3))
            1: add_digits(1);
            2: spec_chars.push_back(CH_STAR);
            default: ;
        endcase
        // precision
        case ($urandom_range(0, 3))
            1: begin
                spec_chars.push_back(CH_DOT);
                add_digits(0);
            end
            2: begin
                spec_chars.push_back(CH_DOT);
                spec_chars.push_back(CH_STAR);
            end
            3: spec_chars.push_back(CH_DOT);
            default: ;
        endcase
        // length modifier, sometimes a tripled letter
        case ($urandom_range(0, 5))
            1: spec_chars.push_back(CH_L);
            2: repeat (2) spec_chars.push_back(CH_L);
            3: spec_chars.push_back(CH_H);
            4: repeat (2) spec_chars.push_back(CH_H);
            5: begin
                c = $urandom_range(0, 1) ? CH_L : CH_H;
                repeat (3) spec_chars.push_back(c);
            end
            default: ;
        endcase
        // terminating character
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_HASH, CH_DASH, CH_SPACE, CH_PLUS, CH_DOT, CH_STAR, CH_L, CH_H,
                         [CH_ZERO:CH_NINE]});
        spec_chars.push_back(c);
        mark = ($urandom_range(0, 9) != 0);
        foreach (spec_chars[i]) send_char(spec_chars[i], pick_arg(), mark && (i == 0));
    endtask

    // Main stimulus
    initial begin
        logic held;
        logic drained;
        held             = 1'b0;
        drained          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.spec_char  = 8'd0;
        in_if.star_arg   = 32'd0;
        in_if.spec_start = 1'b0;
        i_rst_n          = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // flag rules, most negative star width, negative star precision, tripled l
        send_text("#0+ -", 1'b1);
        send_char(CH_STAR, 32'h8000_0000, 1'b0);
        send_char(CH_DOT, 32'd0, 1'b0);
        send_char(CH_STAR, -32'sd5, 1'b0);
        send_text("llld", 1'b0);
        // leading zero, run ends, width replaced, width saturation, hh
        send_text("09-3000000000.7hhx", 1'b1);
        // empty precision, zero blocked by open precision, start mark drops the h length
        send_text(".h0", 1'b1);
        send_char(CH_L, 32'd0, 1'b1);
        send_char(8'h00, 32'hFFFF_FFFF, 1'b0);
        send_char(8'hFF, 32'd0, 1'b1);

        // Random specifiers mixed with noise
        while (sent_chars < RANDOM_CHARS) begin
            if (!held && sent_chars >= 300) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!drained && sent_chars >= 550) begin
                while (sb.pending_results.size() != 0) @(negedge i_clk);
                drained = 1'b1;
            end
            send_idle = ((sent_chars / 120) % 3) != 1;
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_char(8'($urandom), pick_arg(), 1'($urandom_range(0, 1)));
            end else begin
                send_random_spec();
            end
        end
        in_if.valid = 1'b0;

        // Drain and let the pipeline settle
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Summary: %0d characters sent, %0d parsed results checked",
                 sb.n_chars, sb.n_results);
        $display("Covered flag rules, saturating runs, star arguments, length pairs, "
                 , "output hold and drain pause");
        if (sb.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
